### rtl/ctts_pkg.sv
// shared types and codes of the cooperative task scheduler table
package ctts_pkg;

   // table size, tied to the 4-bit slot and 5-bit slot_out fields
   localparam int MAX_TASKS = 16;

   typedef logic [2:0]  cmd_type;
   typedef logic [7:0]  handle_type;
   typedef logic [31:0] word_type;
   typedef logic [3:0]  slot_type;
   typedef logic [1:0]  kind_type;
   typedef logic [4:0]  slot_out_type;
   typedef logic [7:0]  pend_type;

   localparam cmd_type CMD_TICK     = 3'd0;
   localparam cmd_type CMD_ADD      = 3'd1;
   localparam cmd_type CMD_DELETE   = 3'd2;
   localparam cmd_type CMD_DISPATCH = 3'd3;
   localparam cmd_type CMD_CLEAR    = 3'd4;

   localparam kind_type KIND_ACK    = 2'd0;
   localparam kind_type KIND_ADD    = 2'd1;
   localparam kind_type KIND_DELETE = 2'd2;
   localparam kind_type KIND_RUN    = 2'd3;

   localparam pend_type PEND_MAX = 8'd255;

   // what one cell does in a cycle
   typedef logic [1:0] cell_op_type;
   localparam cell_op_type CELL_HOLD  = 2'd0;
   localparam cell_op_type CELL_TICK  = 2'd1;
   localparam cell_op_type CELL_SHIFT = 2'd2;
   localparam cell_op_type CELL_LOAD  = 2'd3;

   typedef struct packed {
      handle_type handle;
      word_type   delay;
      word_type   period;
      pend_type   pending;
   } entry_type;

endpackage

### rtl/ctts_if.sv
// request and response channel interfaces of the task scheduler table
interface ctts_req_if import ctts_pkg::*; ();
   logic       valid;
   logic       ready;
   cmd_type    command;
   handle_type task_handle;
   word_type   first_delay;
   word_type   period;
   slot_type   slot;

   modport source(output valid, command, task_handle, first_delay, period, slot,
                  input ready);
   modport sink(input valid, command, task_handle, first_delay, period, slot,
                output ready);
endinterface

interface ctts_rsp_if import ctts_pkg::*; ();
   logic         valid;
   logic         ready;
   kind_type     result_kind;
   slot_out_type slot_out;
   logic         ok;
   handle_type   handle_out;
   logic         last;

   modport source(output valid, result_kind, slot_out, ok, handle_out, last,
                  input ready);
   modport sink(input valid, result_kind, slot_out, ok, handle_out, last,
                output ready);
endinterface

### rtl/ctts_cell.sv
// one table entry: holds, counts down, takes its neighbor or loads a new entry
module ctts_cell import ctts_pkg::*; (
   input  logic        clock,
   input  cell_op_type op,
   input  entry_type   nbr,
   input  entry_type   load_val,
   output entry_type   q
);

   entry_type q_ff;
   entry_type q_in;

   always_comb begin
      q_in = q_ff;
      unique case (op)
         CELL_HOLD: begin
            q_in = q_ff;
         end
         CELL_TICK: begin
            if (q_ff.delay != '0) begin
               q_in.delay = q_ff.delay - 32'd1;
            end else begin
               // zero period wraps to all ones
               q_in.delay = q_ff.period - 32'd1;
               if (q_ff.pending != PEND_MAX) begin
                  q_in.pending = q_ff.pending + 8'd1;
               end
            end
         end
         CELL_SHIFT: begin
            q_in = nbr;
         end
         CELL_LOAD: begin
            q_in = load_val;
         end
         default: begin
            q_in = q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

### rtl/cooperative_task_scheduler_table.sv
// top level of the cooperative task scheduler table
//
//   channel  direction  transaction
//   req_ch   in         command, task_handle, first_delay, period, slot
//   rsp_ch   out        result_kind, slot_out, ok, handle_out, last
//
// tick, add, delete, clear and unknown commands give a registered result from the
// execute state after accept; dispatch gives its final acknowledge once the table has
// rotated one entry a cycle, while rsp_ch is not stalled, through cell 0 to visit every task.
// a command is taken only while no other command is in progress.
// a result that is not taken holds the table until rsp_ch.ready rises.
// synchronous reset empties the table; entry contents are not cleared.
module cooperative_task_scheduler_table import ctts_pkg::*; (
   input logic       clock,
   input logic       reset,
   ctts_req_if.sink   req_ch,
   ctts_rsp_if.source rsp_ch
);

   localparam int CW   = $clog2(MAX_TASKS + 1);
   localparam int CMPW = CW + 4;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DISP = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;

   cmd_type    cmd_ff, cmd_in;
   handle_type handle_ff, handle_in;
   word_type   first_ff, first_in;
   word_type   period_ff, period_in;
   slot_type   slot_ff, slot_in;

   logic         rsp_valid_ff, rsp_valid_in;
   kind_type     kind_ff, kind_in;
   slot_out_type slot_out_ff, slot_out_in;
   logic         ok_ff, ok_in;
   handle_type   handle_out_ff, handle_out_in;
   logic         last_ff, last_in;

   logic out_free;
   logic do_tick, do_add, do_del, do_rot, rot_keep;
   logic [CW-1:0] rot_count;
   logic [CMPW-1:0] slot_x, count_x;

   entry_type   cell_q   [MAX_TASKS];
   cell_op_type cell_op  [MAX_TASKS];
   entry_type   add_entry, head_mod, load_val;
   logic        head_run, head_drop;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign slot_x       = CMPW'(slot_ff);
   assign count_x      = CMPW'(count_ff);

   always_comb begin
      add_entry.handle  = handle_ff;
      add_entry.delay   = first_ff;
      add_entry.period  = period_ff;
      add_entry.pending = '0;
   end

   // head of the rotation during dispatch
   always_comb begin
      head_run  = (cell_q[0].pending != '0);
      head_drop = head_run && (cell_q[0].period == '0);
      head_mod  = cell_q[0];
      if (head_run) begin
         head_mod.pending = cell_q[0].pending - 8'd1;
      end
   end

   assign load_val = do_rot ? head_mod : add_entry;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      first_in      = first_ff;
      period_in     = period_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      kind_in       = kind_ff;
      slot_out_in   = slot_out_ff;
      ok_in         = ok_ff;
      handle_out_in = handle_out_ff;
      last_in       = last_ff;
      do_tick       = 1'b0;
      do_add        = 1'b0;
      do_del        = 1'b0;
      do_rot        = 1'b0;
      rot_keep      = 1'b0;
      rot_count     = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in    = req_ch.command;
               handle_in = req_ch.task_handle;
               first_in  = req_ch.first_delay;
               period_in = req_ch.period;
               slot_in   = req_ch.slot;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               kind_in       = KIND_ACK;
               slot_out_in   = '0;
               ok_in         = 1'b0;
               handle_out_in = '0;
               last_in       = 1'b1;
               unique case (cmd_ff)
                  CMD_TICK: begin
                     do_tick = 1'b1;
                  end
                  CMD_ADD: begin
                     kind_in = KIND_ADD;
                     if (count_ff != CW'(MAX_TASKS)) begin
                        do_add      = 1'b1;
                        slot_out_in = 5'(count_ff);
                        count_in    = count_ff + CW'(1);
                     end else begin
                        slot_out_in = 5'(MAX_TASKS);
                     end
                  end
                  CMD_DELETE: begin
                     kind_in = KIND_DELETE;
                     if (slot_x < count_x) begin
                        do_del   = 1'b1;
                        ok_in    = 1'b1;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  CMD_DISPATCH: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                     remain_in    = count_ff;
                     state_in     = ST_DISP;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_DISP: begin
            if (out_free) begin
               if (remain_ff != '0) begin
                  do_rot    = 1'b1;
                  rot_keep  = !head_drop;
                  rot_count = count_ff - (head_drop ? CW'(1) : CW'(0));
                  count_in  = rot_count;
                  remain_in = remain_ff - CW'(1);
                  if (head_run) begin
                     rsp_valid_in  = 1'b1;
                     kind_in       = KIND_RUN;
                     slot_out_in   = '0;
                     ok_in         = 1'b0;
                     handle_out_in = cell_q[0].handle;
                     last_in       = 1'b0;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  kind_in       = KIND_ACK;
                  slot_out_in   = '0;
                  ok_in         = 1'b0;
                  handle_out_in = '0;
                  last_in       = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
         entry_type nbr;

         if (gi == MAX_TASKS - 1) begin : g_end
            assign nbr = cell_q[gi];
         end else begin : g_mid
            assign nbr = cell_q[gi + 1];
         end

         always_comb begin
            priority if (do_tick && (CW'(gi) < count_ff)) begin
               cell_op[gi] = CELL_TICK;
            end else if (do_add && (CW'(gi) == count_ff)) begin
               cell_op[gi] = CELL_LOAD;
            end else if (do_del && (CMPW'(gi) >= slot_x)) begin
               cell_op[gi] = CELL_SHIFT;
            end else if (do_rot) begin
               // a kept head goes back in at the tail of the table
               cell_op[gi] = (rot_keep && (CW'(gi + 1) == rot_count)) ? CELL_LOAD
                                                                      : CELL_SHIFT;
            end else begin
               cell_op[gi] = CELL_HOLD;
            end
         end

         ctts_cell u_cell (
            .clock    (clock),
            .op       (cell_op[gi]),
            .nbr      (nbr),
            .load_val (load_val),
            .q        (cell_q[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      handle_ff     <= handle_in;
      first_ff      <= first_in;
      period_ff     <= period_in;
      slot_ff       <= slot_in;
      kind_ff       <= kind_in;
      slot_out_ff   <= slot_out_in;
      ok_ff         <= ok_in;
      handle_out_ff <= handle_out_in;
      last_ff       <= last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.slot_out    = slot_out_ff;
   assign rsp_ch.ok          = ok_ff;
   assign rsp_ch.handle_out  = handle_out_ff;
   assign rsp_ch.last        = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("task count beyond table size");

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP) |-> (remain_ff <= count_ff))
      else $error("dispatch walk exceeds table contents");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_EXEC))
      else $error("accepted command not executed");

   a_run_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == KIND_RUN)) |-> !last_ff)
      else $error("run result marked last");

endmodule

### tb/sched_predict_compare.sv
`timescale 1ns / 1ps
// predicts the scheduler table's results from observed commands and compares them
module sched_predict_compare import ctts_pkg::*; (
   input  logic clock,
   input  logic reset,
   ctts_req_if  req_ch,
   ctts_rsp_if  rsp_ch,
   output int   mismatches,
   output int   outstanding
);

   typedef struct {
      kind_type     kind;
      slot_out_type slot;
      logic         ok;
      handle_type   handle;
      logic         last;
   } sched_result_type;

   entry_type        task_table [MAX_TASKS];
   int unsigned      task_total;
   sched_result_type expected_results [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      task_total  = 0;
   end

   function automatic void queue_result(kind_type kind, slot_out_type slot, logic ok,
                                        handle_type handle, logic last);
      sched_result_type r;
      r.kind   = kind;
      r.slot   = slot;
      r.ok     = ok;
      r.handle = handle;
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   // compacts the table over the removed position
   function automatic logic drop_entry(int unsigned pos);
      if (pos >= task_total) return 1'b0;
      for (int unsigned j = pos + 1; j < task_total; j++) task_table[j - 1] = task_table[j];
      task_total--;
      return 1'b1;
   endfunction

   function automatic void predict_command(cmd_type command, handle_type handle,
                                           word_type first_delay, word_type period,
                                           slot_type slot);
      int unsigned i;
      logic removed;
      case (command)
         CMD_TICK: begin
            for (i = 0; i < task_total; i++) begin
               if (task_table[i].delay != '0) begin
                  task_table[i].delay = task_table[i].delay - 1'b1;
               end else begin
                  // zero period wraps the reload to all ones
                  task_table[i].delay = task_table[i].period - 1'b1;
                  if (task_table[i].pending != PEND_MAX)
                     task_table[i].pending = task_table[i].pending + 1'b1;
               end
            end
            queue_result(KIND_ACK, '0, 1'b0, '0, 1'b1);
         end
         CMD_ADD: begin
            if (task_total < MAX_TASKS) begin
               task_table[task_total].handle  = handle;
               task_table[task_total].delay   = first_delay;
               task_table[task_total].period  = period;
               task_table[task_total].pending = '0;
               queue_result(KIND_ADD, slot_out_type'(task_total), 1'b0, '0, 1'b1);
               task_total++;
            end else begin
               queue_result(KIND_ADD, slot_out_type'(MAX_TASKS), 1'b0, '0, 1'b1);
            end
         end
         CMD_DELETE: begin
            removed = drop_entry(slot);
            queue_result(KIND_DELETE, '0, removed, '0, 1'b1);
         end
         CMD_DISPATCH: begin
            i = 0;
            while (i < task_total) begin
               if (task_table[i].pending != '0) begin
                  task_table[i].pending = task_table[i].pending - 1'b1;
                  queue_result(KIND_RUN, '0, 1'b0, task_table[i].handle, 1'b0);
                  // one-shot leaves, the entry shifted in is looked at next
                  if (task_table[i].period == '0) begin
                     void'(drop_entry(i));
                     continue;
                  end
               end
               i++;
            end
            queue_result(KIND_ACK, '0, 1'b0, '0, 1'b1);
         end
         CMD_CLEAR: begin
            for (i = 0; i < MAX_TASKS; i++) task_table[i] = '0;
            task_total = 0;
            queue_result(KIND_ACK, '0, 1'b0, '0, 1'b1);
         end
         default: begin
            queue_result(KIND_ACK, '0, 1'b0, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_result();
      sched_result_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result transaction: result_kind %0d handle_out %0d",
                rsp_ch.result_kind, rsp_ch.handle_out);
         mismatches++;
         return;
      end
      want = expected_results.pop_front();
      if (rsp_ch.result_kind !== want.kind) begin
         $error("result_kind mismatch: expected %0d, actual %0d", want.kind, rsp_ch.result_kind);
         mismatches++;
      end
      if (rsp_ch.slot_out !== want.slot) begin
         $error("slot_out mismatch: expected %0d, actual %0d", want.slot, rsp_ch.slot_out);
         mismatches++;
      end
      if (rsp_ch.ok !== want.ok) begin
         $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_ch.ok);
         mismatches++;
      end
      if (rsp_ch.handle_out !== want.handle) begin
         $error("handle_out mismatch: expected %0d, actual %0d", want.handle, rsp_ch.handle_out);
         mismatches++;
      end
      if (rsp_ch.last !== want.last) begin
         $error("last mismatch: expected %0d, actual %0d", want.last, rsp_ch.last);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         task_total = 0;
         expected_results.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_command(req_ch.command, req_ch.task_handle, req_ch.first_delay,
                            req_ch.period, req_ch.slot);
         if (rsp_ch.valid && rsp_ch.ready) check_result();
      end
      outstanding = expected_results.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// stimulus, receiver stalls and verdict for the cooperative task scheduler table
module tb import ctts_pkg::*; ();

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 10;
   localparam int SATURATE_TICKS  = 260;
   localparam cmd_type CMD_UNKNOWN_FIRST = 3'd5;
   localparam cmd_type CMD_UNKNOWN_LAST  = 3'd7;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   take_idle_pct;
   int   items_sent;
   logic hold_off_due;
   int   mismatches;
   int   outstanding;
   int   cycle_count;

   ctts_req_if req_ch ();
   ctts_rsp_if rsp_ch ();

   cooperative_task_scheduler_table dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   sched_predict_compare compare_unit (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, or one long hold-off when asked for
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_command(cmd_type command, handle_type handle, word_type first_delay,
                               word_type period, slot_type slot);
      req_ch.valid       <= 1'b1;
      req_ch.command     <= command;
      req_ch.task_handle <= handle;
      req_ch.first_delay <= first_delay;
      req_ch.period      <= period;
      req_ch.slot        <= slot;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // fields the command does not use carry noise
   task automatic send_with_noise(cmd_type command);
      send_command(command, handle_type'($urandom), word_type'($urandom),
                   word_type'($urandom), slot_type'($urandom));
   endtask

   // mostly short delays and periods so that tasks come due
   function automatic word_type pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return '0;
      if (r < 75) return word_type'($urandom_range(1, 3));
      if (r < 90) return word_type'($urandom_range(4, 12));
      return word_type'($urandom);
   endfunction

   task automatic send_random_add();
      send_command(CMD_ADD, handle_type'($urandom), pick_count(), pick_count(),
                   slot_type'($urandom));
   endtask

   task automatic send_random_command();
      int r;
      slot_type s;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         send_random_add();
      end else if (r < 60) begin
         send_with_noise(CMD_TICK);
      end else if (r < 75) begin
         send_with_noise(CMD_DISPATCH);
      end else if (r < 87) begin
         s = ($urandom_range(0, 99) < 70) ? slot_type'($urandom_range(0, 5))
                                          : slot_type'($urandom);
         send_command(CMD_DELETE, handle_type'($urandom), word_type'($urandom),
                      word_type'($urandom), s);
      end else if (r < 92) begin
         send_with_noise(CMD_CLEAR);
      end else begin
         send_with_noise(cmd_type'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST)));
      end
   endtask

   task automatic tick_burst();
      repeat ($urandom_range(1, 8)) send_with_noise(CMD_TICK);
      send_with_noise(CMD_DISPATCH);
   endtask

   task automatic run_phase(int send_pct, int take_pct);
      int start;
      int r;
      send_idle_pct = send_pct;
      take_idle_pct = take_pct;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // one more add than fits, so the full table answer shows up
            repeat (MAX_TASKS + 1) send_random_add();
         end else if (r < 25) begin
            tick_burst();
         end else begin
            send_random_command();
         end
      end
   endtask

   task automatic pressure_burst();
      hold_off_due = 1'b1;
      send_with_noise(CMD_CLEAR);
      repeat (MAX_TASKS + 1)
         send_command(CMD_ADD, handle_type'($urandom), '0, 32'd1, slot_type'($urandom));
      send_with_noise(CMD_TICK);
      send_with_noise(CMD_DISPATCH);
      send_with_noise(CMD_TICK);
      send_with_noise(CMD_DISPATCH);
   endtask

   task automatic saturate_pending();
      send_with_noise(CMD_CLEAR);
      send_command(CMD_ADD, handle_type'($urandom), '0, 32'd1, '0);
      send_command(CMD_ADD, handle_type'($urandom), '0, '0, '0);
      send_command(CMD_ADD, handle_type'($urandom), 32'd2, 32'd3, '0);
      repeat (SATURATE_TICKS) send_with_noise(CMD_TICK);
      send_with_noise(CMD_DISPATCH);
      send_with_noise(CMD_DISPATCH);
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_TICK;
      req_ch.task_handle <= '0;
      req_ch.first_delay <= '0;
      req_ch.period      <= '0;
      req_ch.slot        <= '0;
      hold_off_due  = 1'b0;
      send_idle_pct = 12;
      take_idle_pct = 75;
      items_sent    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table
      send_command(CMD_TICK, '0, '0, '0, '0);
      send_command(CMD_DISPATCH, '0, '0, '0, '0);
      send_command(CMD_DELETE, '0, '0, '0, '0);
      // two one-shots back to back, an all-ones entry, a period of one
      send_command(CMD_ADD, 8'h00, '0, '0, '0);
      send_command(CMD_ADD, 8'hff, '0, '0, '0);
      send_command(CMD_ADD, 8'h3c, 32'hffff_ffff, 32'hffff_ffff, '0);
      send_command(CMD_ADD, 8'ha5, '0, 32'd1, '0);
      send_command(CMD_TICK, '0, '0, '0, '0);
      send_command(CMD_TICK, '0, '0, '0, '0);
      send_command(CMD_DISPATCH, '0, '0, '0, '0);
      send_command(CMD_DISPATCH, '0, '0, '0, '0);
      // slot equal to the count, slot at the top, then a good one
      send_command(CMD_DELETE, '0, '0, '0, 4'd2);
      send_command(CMD_DELETE, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
      send_command(CMD_DELETE, '0, '0, '0, '0);
      send_command(CMD_UNKNOWN_FIRST, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
      send_command(cmd_type'(CMD_UNKNOWN_FIRST + 1'b1), '0, '0, '0, '0);
      send_command(CMD_UNKNOWN_LAST, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
      send_command(CMD_CLEAR, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
      send_command(CMD_ADD, 8'h81, 32'h8000_0001, '0, '0);
      send_command(CMD_DELETE, '0, '0, '0, '0);

      run_phase(12, 75);
      run_phase(75, 12);
      send_idle_pct = 0;
      take_idle_pct = 0;
      pressure_burst();
      saturate_pending();
      run_phase(0, 0);
      req_ch.valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (MAX_TASKS + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
